@@ design/hsv_pkg.sv @@
// Shared types, sector codes and arithmetic helpers for the HSV to RGB converter.
// Depends on nothing; used by hsv_out_stage and hsv_to_rgb_converter.
package hsv_pkg;

  // Color sector codes taken from the integer part of hue * 6.
  localparam logic [2:0] SECTOR_RED_YELLOW   = 3'd0;
  localparam logic [2:0] SECTOR_YELLOW_GREEN = 3'd1;
  localparam logic [2:0] SECTOR_GREEN_CYAN   = 3'd2;
  localparam logic [2:0] SECTOR_CYAN_BLUE    = 3'd3;
  localparam logic [2:0] SECTOR_BLUE_MAGENTA = 3'd4;
  localparam logic [2:0] SECTOR_MAGENTA_RED  = 3'd5;

  localparam logic [7:0]  FULL_SCALE = 8'd255;
  localparam logic [16:0] FRAC_ONE   = 17'h10000;

  // Products brightness * (255 - x) handed to the final stage.
  typedef struct packed {
    logic        valid;
    logic [2:0]  sector;
    logic [7:0]  v;
    logic [15:0] prod_p;
    logic [15:0] prod_q;
    logic [15:0] prod_t;
  } hsv_prod_t;

  // Exact floor(x / 255) for any x up to 255 * 255, by the
  // reciprocal identity (x + (x >> 8) + 1) >> 8.
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] sum;
    begin
      sum = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
      div255 = sum[15:8];
    end
  endfunction

endpackage

@@ design/hsv_out_stage.sv @@
// Final pipeline stage: divides the three products by 255, orders the
// channels by sector and forms the byte-swapped RGB565 word. Uses hsv_pkg.
module hsv_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  hsv_pkg::hsv_prod_t prod,
  output logic              done,
  output logic [7:0]        red,
  output logic [7:0]        green,
  output logic [7:0]        blue,
  output logic [15:0]       packed_565
);
  import hsv_pkg::*;

  logic [7:0] p_val;
  logic [7:0] q_val;
  logic [7:0] t_val;
  logic [7:0] red_next;
  logic [7:0] green_next;
  logic [7:0] blue_next;

  // Scale the products back to 8 bits with truncation.
  assign p_val = div255(prod.prod_p);
  assign q_val = div255(prod.prod_q);
  assign t_val = div255(prod.prod_t);

  // Channel order for each sector; codes with no meaning take the first order.
  always_comb begin
    unique case (prod.sector)
      SECTOR_YELLOW_GREEN: begin
        red_next = q_val;  green_next = prod.v; blue_next = p_val;
      end
      SECTOR_GREEN_CYAN: begin
        red_next = p_val;  green_next = prod.v; blue_next = t_val;
      end
      SECTOR_CYAN_BLUE: begin
        red_next = p_val;  green_next = q_val;  blue_next = prod.v;
      end
      SECTOR_BLUE_MAGENTA: begin
        red_next = t_val;  green_next = p_val;  blue_next = prod.v;
      end
      SECTOR_MAGENTA_RED: begin
        red_next = prod.v; green_next = p_val;  blue_next = q_val;
      end
      default: begin
        red_next = prod.v; green_next = t_val;  blue_next = p_val;
      end
    endcase
  end

  // Result strobe follows the valid bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= prod.valid;
    end
  end

  // Result registers.
  always_ff @(posedge clk) begin
    red        <= red_next;
    green      <= green_next;
    blue       <= blue_next;
    packed_565 <= {green_next[4:2], blue_next[7:3], red_next[7:3], green_next[7:5]};
  end

endmodule

@@ design/hsv_to_rgb_converter.sv @@
// HSV to RGB converter: four-stage pipeline, one transfer per clock.
// The item taken with start passes the stage 1, 2 and 3 registers and then the
// hsv_out_stage register that drives done; throughput is one item per cycle.
// busy is held low since the result receiver never stalls the pipeline.
// Synchronous active-high reset clears the valid bits; data registers are
// not reset. Depends on hsv_pkg and hsv_out_stage.
module hsv_to_rgb_converter (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] hue,
  input  logic [7:0]  saturation,
  input  logic [7:0]  brightness,
  output logic        done,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue,
  output logic [15:0] packed_565
);
  import hsv_pkg::*;

  // Stage 1 registers: hue scaled by six.
  logic        s1_valid;
  logic [18:0] s1_h6;
  logic [7:0]  s1_sat;
  logic [7:0]  s1_bri;

  // Stage 2 registers: fractional saturation terms.
  logic        s2_valid;
  logic [2:0]  s2_sector;
  logic [7:0]  s2_sat;
  logic [7:0]  s2_bri;
  logic [7:0]  s2_fq;
  logic [7:0]  s2_ft;

  logic [15:0] s1_frac;
  logic [16:0] s1_frac_inv;
  logic [23:0] s1_fq_prod;
  logic [24:0] s1_ft_prod;
  logic [7:0]  keep_p;
  logic [7:0]  keep_q;
  logic [7:0]  keep_t;

  hsv_prod_t   s3_prod;

  assign busy = 1'b0;

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid       <= 1'b0;
      s2_valid       <= 1'b0;
    end else begin
      s1_valid       <= start;
      s2_valid       <= s1_valid;
    end
  end

  // Stage 1: multiply hue by six.
  always_ff @(posedge clk) begin
    s1_h6  <= ({3'd0, hue} << 2) + ({3'd0, hue} << 1);
    s1_sat <= saturation;
    s1_bri <= brightness;
  end

  // Split into sector and fraction and scale the fraction by saturation.
  assign s1_frac     = s1_h6[15:0];
  assign s1_frac_inv = FRAC_ONE - {1'b0, s1_frac};
  assign s1_fq_prod  = s1_frac * s1_sat;
  assign s1_ft_prod  = s1_frac_inv * s1_sat;

  // Stage 2 registers.
  always_ff @(posedge clk) begin
    s2_sector <= s1_h6[18:16];
    s2_sat    <= s1_sat;
    s2_bri    <= s1_bri;
    s2_fq     <= s1_fq_prod[23:16];
    s2_ft     <= s1_ft_prod[23:16];
  end

  // Stage 3: brightness times the kept share for p, q and t.
  assign keep_p = FULL_SCALE - s2_sat;
  assign keep_q = FULL_SCALE - s2_fq;
  assign keep_t = FULL_SCALE - s2_ft;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_prod.valid <= 1'b0;
    end else begin
      s3_prod.valid <= s2_valid;
    end
    s3_prod.sector <= s2_sector;
    s3_prod.v      <= s2_bri;
    s3_prod.prod_p <= s2_bri * keep_p;
    s3_prod.prod_q <= s2_bri * keep_q;
    s3_prod.prod_t <= s2_bri * keep_t;
  end

  // Stage 4: divide, order the channels and pack.
  hsv_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .prod       (s3_prod),
    .done       (done),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .packed_565 (packed_565)
  );

endmodule

@@ test/tb_hsv_to_rgb_converter.sv @@
// Self-checking testbench for hsv_to_rgb_converter: directed and random pixels,
// a queue-fed start/busy driver and a done-strobe monitor with its own color predictor.
// Depends on hsv_pkg and the hsv_to_rgb_converter RTL.
`timescale 1ns / 100ps

module tb_hsv_to_rgb_converter;
  import hsv_pkg::*;

  // One pixel to convert; hold_for_drain makes the driver wait for an empty pipeline first.
  typedef struct {
    logic [15:0] hue;
    logic [7:0]  saturation;
    logic [7:0]  brightness;
    logic        hold_for_drain;
  } hsv_pixel_t;

  // One converted color as the block should report it.
  typedef struct {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [15:0] pack565;
  } rgb_color_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [15:0] hue;
  logic [7:0]  saturation;
  logic [7:0]  brightness;
  logic        done;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [15:0] packed_565;

  hsv_pixel_t pending_pixels[$];
  rgb_color_t expected_colors[$];
  int         sent_count;
  int         error_count;
  int         idle_percent;
  hsv_pixel_t next_pixel;
  rgb_color_t oldest_color;

  hsv_to_rgb_converter dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .hue        (hue),
    .saturation (saturation),
    .brightness (brightness),
    .done       (done),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .packed_565 (packed_565)
  );

  // Free-running clock with a 4 ns period.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Safety net in case the pipeline hangs or drops results.
  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  // Truncating brightness * keep / 255.
  function automatic logic [7:0] scale_brightness(input logic [7:0] bri, input logic [7:0] keep);
    logic [15:0] product;
    begin
      product = 16'(bri) * 16'(keep);
      scale_brightness = 8'(product / 16'd255);
    end
  endfunction

  // Six-sector HSV to RGB conversion with truncation at every step.
  function automatic rgb_color_t predict_color(input logic [15:0] h, input logic [7:0] s,
                                               input logic [7:0] b);
    logic [18:0] h6;
    logic [2:0]  sector;
    logic [15:0] frac;
    logic [23:0] frac_sat;
    logic [24:0] rest_sat;
    logic [7:0]  fq;
    logic [7:0]  ft;
    logic [7:0]  v;
    logic [7:0]  p;
    logic [7:0]  q;
    logic [7:0]  t;
    rgb_color_t  c;
    begin
      h6       = 19'(h) * 19'd6;
      sector   = h6[18:16];
      frac     = h6[15:0];
      frac_sat = 24'(frac) * 24'(s);
      rest_sat = 25'(FRAC_ONE - 17'(frac)) * 25'(s);
      fq       = frac_sat[23:16];
      ft       = rest_sat[23:16];
      v        = b;
      p        = scale_brightness(b, FULL_SCALE - s);
      q        = scale_brightness(b, FULL_SCALE - fq);
      t        = scale_brightness(b, FULL_SCALE - ft);
      case (sector)
        SECTOR_YELLOW_GREEN: begin c.red = q; c.green = v; c.blue = p; end
        SECTOR_GREEN_CYAN:   begin c.red = p; c.green = v; c.blue = t; end
        SECTOR_CYAN_BLUE:    begin c.red = p; c.green = q; c.blue = v; end
        SECTOR_BLUE_MAGENTA: begin c.red = t; c.green = p; c.blue = v; end
        SECTOR_MAGENTA_RED:  begin c.red = v; c.green = p; c.blue = q; end
        default:             begin c.red = v; c.green = t; c.blue = p; end
      endcase
      c.pack565 = {c.green[4:2], c.blue[7:3], c.red[7:3], c.green[7:5]};
      predict_color = c;
    end
  endfunction

  task automatic queue_pixel(input logic [15:0] h, input logic [7:0] s, input logic [7:0] b,
                             input logic drain);
    hsv_pixel_t px;
    begin
      px.hue            = h;
      px.saturation     = s;
      px.brightness     = b;
      px.hold_for_drain = drain;
      pending_pixels.push_back(px);
    end
  endtask

  // Random 8-bit level with extra weight on the extremes.
  function automatic logic [7:0] pick_level();
    int roll;
    begin
      roll = $urandom_range(0, 99);
      if (roll < 6) pick_level = 8'd0;
      else if (roll < 12) pick_level = 8'd255;
      else if (roll < 15) pick_level = 8'($urandom_range(1, 2));
      else pick_level = 8'($urandom_range(0, 255));
    end
  endfunction

  // Random hue, sometimes placed right at a sector boundary.
  function automatic logic [15:0] pick_hue();
    int boundary;
    begin
      if ($urandom_range(0, 99) < 20) begin
        boundary = ($urandom_range(0, 6) * 65536 + 5) / 6;
        pick_hue = 16'(boundary + $urandom_range(0, 4) - 2);
      end else begin
        pick_hue = 16'($urandom_range(0, 65535));
      end
    end
  endfunction

  task automatic check_field(input string field, input logic [15:0] exp_val,
                             input logic [15:0] act_val);
    begin
      if (exp_val !== act_val) begin
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, exp_val, act_val);
        error_count++;
      end
    end
  endtask

  // Driver: presents the next pixel once the current transfer is taken, with random gaps.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && busy) begin
      // Transfer not taken yet; hold the item.
    end else begin
      if (start) sent_count++;
      idle_percent = (sent_count < 320) ? 19 : (sent_count < 640) ? 69 : 0;
      if (pending_pixels.size() > 0 && $urandom_range(0, 99) >= idle_percent &&
          !(pending_pixels[0].hold_for_drain && (start || expected_colors.size() != 0))) begin
        next_pixel = pending_pixels.pop_front();
        hue        <= next_pixel.hue;
        saturation <= next_pixel.saturation;
        brightness <= next_pixel.brightness;
        start      <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: records each accepted pixel's color, then checks each done strobe in order.
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) expected_colors.push_back(predict_color(hue, saturation, brightness));
      if (done) begin
        if (expected_colors.size() == 0) begin
          $display("%0t: unexpected result, expected none actual r=%0d g=%0d b=%0d",
                   $time, red, green, blue);
          error_count++;
        end else begin
          oldest_color = expected_colors.pop_front();
          check_field("red", 16'(oldest_color.red), 16'(red));
          check_field("green", 16'(oldest_color.green), 16'(green));
          check_field("blue", 16'(oldest_color.blue), 16'(blue));
          check_field("packed_565", oldest_color.pack565, packed_565);
        end
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    rst         = 1'b1;
    start       = 1'b0;
    hue         = 16'd0;
    saturation  = 8'd0;
    brightness  = 8'd0;
    sent_count  = 0;
    error_count = 0;

    // Directed: extremes, zero saturation, zero brightness, every sector and its edges.
    queue_pixel(16'd0,     8'd0,   8'd0,   1'b0);
    queue_pixel(16'd65535, 8'd255, 8'd255, 1'b0);
    queue_pixel(16'd12345, 8'd0,   8'd200, 1'b0);
    queue_pixel(16'd40000, 8'd0,   8'd255, 1'b0);
    queue_pixel(16'd50000, 8'd255, 8'd0,   1'b0);
    queue_pixel(16'd0,     8'd255, 8'd255, 1'b0);
    queue_pixel(16'd10922, 8'd255, 8'd255, 1'b0);
    queue_pixel(16'd10923, 8'd255, 8'd255, 1'b0);
    queue_pixel(16'd21845, 8'd255, 8'd255, 1'b0);
    queue_pixel(16'd21846, 8'd255, 8'd255, 1'b0);
    queue_pixel(16'd32767, 8'd255, 8'd255, 1'b0);
    queue_pixel(16'd32768, 8'd255, 8'd255, 1'b0);
    queue_pixel(16'd43690, 8'd255, 8'd255, 1'b0);
    queue_pixel(16'd43691, 8'd255, 8'd255, 1'b0);
    queue_pixel(16'd54613, 8'd255, 8'd255, 1'b0);
    queue_pixel(16'd54614, 8'd255, 8'd255, 1'b0);
    queue_pixel(16'd5461,  8'd128, 8'd200, 1'b0);
    queue_pixel(16'd16384, 8'd1,   8'd255, 1'b0);
    queue_pixel(16'd27306, 8'd254, 8'd1,   1'b0);
    queue_pixel(16'd38229, 8'd77,  8'd180, 1'b0);
    queue_pixel(16'd49151, 8'd200, 8'd99,  1'b0);
    queue_pixel(16'd60074, 8'd170, 8'd240, 1'b0);
    queue_pixel(16'hAAAA,  8'h55,  8'hAA,  1'b0);
    queue_pixel(16'h5555,  8'hAA,  8'h55,  1'b0);

    // Random pixels; two of them wait for the pipeline to drain first.
    for (int i = 0; i < 926; i++) begin
      queue_pixel(pick_hue(), pick_level(), pick_level(), (i == 0) || (i == 500));
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (pending_pixels.size() != 0 || start || expected_colors.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (error_count == 0 && expected_colors.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/hsv_pkg.sv
design/hsv_out_stage.sv
design/hsv_to_rgb_converter.sv
test/tb_hsv_to_rgb_converter.sv
